>>> design/xxhash64_stream_hasher_macros.svh
// Assertion macros for the xxhash64 stream hasher.
`ifndef XXHASH64_STREAM_HASHER_MACROS_SVH
`define XXHASH64_STREAM_HASHER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define XXH_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true.
`define XXH_NEVER(lbl, cond, msg) \
	`XXH_CHECK(lbl, !(cond), msg)

`endif

>>> design/xxh64_pkg.sv
// Package: primes, datapath commands and status for the xxhash64 hasher.
`default_nettype none
package xxh64_pkg;

	localparam logic [63:0] PRIME_1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PRIME_2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PRIME_3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PRIME_4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PRIME_5 = 64'h27D4EB2F165667C5;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_ACCEPT,
		DP_X_SRC,
		DP_MUL,
		DP_ADDROT,
		DP_LANE_WR,
		DP_H_CONV,
		DP_H_SHORT,
		DP_H_LEN,
		DP_H_XOR,
		DP_H_ROT,
		DP_H_ADDK,
		DP_H_SHR,
		DP_DONE
	} dp_op_t;

	typedef enum logic [2:0] {
		SRC_PEND,
		SRC_WORD,
		SRC_LANE,
		SRC_LO32,
		SRC_BYTE
	} src_t;

	typedef enum logic [2:0] {
		K_P1,
		K_P2,
		K_P3,
		K_P4,
		K_P5
	} kconst_t;

	typedef enum logic {
		MD_X,
		MD_H
	} mdst_t;

	typedef enum logic [1:0] {
		ROT_27,
		ROT_23,
		ROT_11
	} rot_t;

	typedef enum logic [1:0] {
		SHR_33,
		SHR_29,
		SHR_32
	} shr_t;

	typedef struct packed {
		dp_op_t      op;
		src_t        src;
		logic [2:0]  idx;
		logic        use_lane;
		kconst_t     k;
		mdst_t       mdst;
		rot_t        rot;
		shr_t        shr;
	} dp_cmd_t;

	typedef struct packed {
		logic        need_stripe;
		logic        in_last;
		logic [1:0]  pend_cnt;
		logic [3:0]  nb;
		logic        last;
		logic        long_msg;
		logic        mul_done;
		logic        out_busy;
	} dp_status_t;

	function automatic logic [63:0] kval(input kconst_t k);
		case (k)
			K_P1: return PRIME_1;
			K_P2: return PRIME_2;
			K_P3: return PRIME_3;
			K_P4: return PRIME_4;
			K_P5: return PRIME_5;
			default: return PRIME_1;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> design/xxh64_mul.sv
// Iterative 64x64 multiplier, low 64 bits, one 32x32 product per cycle.
`default_nettype none
module xxh64_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      p
);
	logic [1:0]  cnt_q;
	logic [63:0] acc_q;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [31:0] sum_hi;

	// step 0: lo*lo, step 1: a_lo*b_hi, step 2: a_hi*b_lo (cross terms land in upper half)
	always_comb begin
		case (cnt_q)
			2'd0: begin
				ma = a[31:0];
				mb = b[31:0];
			end
			2'd1: begin
				ma = a[31:0];
				mb = b[63:32];
			end
			default: begin
				ma = a[63:32];
				mb = b[31:0];
			end
		endcase
	end

	assign prod   = 64'(ma) * 64'(mb);
	assign sum_hi = acc_q[63:32] + prod[31:0];
	assign done   = go && (cnt_q == 2'd2);
	assign p      = {sum_hi, acc_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (!go || cnt_q == 2'd2) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 2'd0) begin
			acc_q <= prod;
		end else begin
			acc_q <= {sum_hi, acc_q[31:0]};
		end
	end
endmodule
`default_nettype wire

>>> design/xxh64_dp.sv
// Datapath: lanes, stripe buffer, length, hash register and shared multiplier.
`default_nettype none
module xxh64_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [63:0]           cfg_data,
	input  wire logic                  in_valid,
	input  wire logic [63:0]           data_word,
	input  wire logic [3:0]            byte_count,
	input  wire logic                  last_item,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [63:0]                hash_value,
	input  wire xxh64_pkg::dp_cmd_t    cmd,
	output xxh64_pkg::dp_status_t      st
);
	import xxh64_pkg::*;

	logic [63:0] seed_q;
	logic [63:0] lane_q [4];
	logic [63:0] pend_q [3];
	logic [63:0] word_q;
	logic [3:0]  nb_q;
	logic        last_q;
	logic [63:0] len_q;
	logic [1:0]  pc_q;
	logic        in_msg_q;
	logic [63:0] x_q;
	logic [63:0] h_q;
	logic [63:0] out_q;
	logic        out_valid_q;

	logic        accept;
	logic [3:0]  nb_sat;
	logic        need_stripe;
	logic [63:0] src_val;
	logic [63:0] mul_a;
	logic [63:0] mul_p;
	logic        mul_done;
	logic [63:0] addsum;
	logic [63:0] h_rot;
	logic [63:0] h_shr;
	logic [63:0] conv;

	assign accept      = (cmd.op == DP_ACCEPT) && in_valid;
	assign nb_sat      = (byte_count > 4'd8) ? 4'd8 : byte_count;
	assign need_stripe = (pc_q == 2'd3) && (!last_item || nb_sat == 4'd8);

	always_comb begin
		case (cmd.src)
			SRC_PEND: src_val = pend_q[cmd.idx[1:0] == 2'd3 ? 2'd2 : cmd.idx[1:0]];
			SRC_WORD: src_val = word_q;
			SRC_LANE: src_val = lane_q[cmd.idx[1:0]];
			SRC_LO32: src_val = {32'd0, word_q[31:0]};
			SRC_BYTE: src_val = {56'd0, word_q[cmd.idx*8 +: 8]};
			default:  src_val = word_q;
		endcase
	end

	assign mul_a = (cmd.mdst == MD_X) ? x_q : h_q;

	xxh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.op == DP_MUL),
		.a      (mul_a),
		.b      (kval(cmd.k)),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign addsum = x_q + (cmd.use_lane ? lane_q[cmd.idx[1:0]] : 64'd0);

	always_comb begin
		case (cmd.rot)
			ROT_27:  h_rot = {h_q[36:0], h_q[63:37]};
			ROT_23:  h_rot = {h_q[40:0], h_q[63:41]};
			ROT_11:  h_rot = {h_q[52:0], h_q[63:53]};
			default: h_rot = h_q;
		endcase
		case (cmd.shr)
			SHR_33:  h_shr = h_q ^ (h_q >> 33);
			SHR_29:  h_shr = h_q ^ (h_q >> 29);
			SHR_32:  h_shr = h_q ^ (h_q >> 32);
			default: h_shr = h_q;
		endcase
	end

	assign conv = {lane_q[0][62:0], lane_q[0][63]} + {lane_q[1][56:0], lane_q[1][63:57]}
		+ {lane_q[2][51:0], lane_q[2][63:52]} + {lane_q[3][45:0], lane_q[3][63:46]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 64'd0;
			len_q       <= 64'd0;
			pc_q        <= 2'd0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				in_msg_q <= 1'b1;
				len_q    <= len_q + (last_item ? 64'(nb_sat) : 64'd8);
				if (need_stripe) begin
					pc_q <= 2'd0;
				end else if (!last_item) begin
					pc_q <= pc_q + 2'd1;
				end
			end
			if (cmd.op == DP_DONE) begin
				len_q       <= 64'd0;
				pc_q        <= 2'd0;
				in_msg_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= data_word;
			last_q <= last_item;
			nb_q   <= need_stripe ? 4'd0 : nb_sat;
			if (!last_item && pc_q != 2'd3) begin
				pend_q[pc_q] <= data_word;
			end
			if (!in_msg_q) begin
				lane_q[0] <= seed_q + PRIME_1 + PRIME_2;
				lane_q[1] <= seed_q + PRIME_2;
				lane_q[2] <= seed_q;
				lane_q[3] <= seed_q - PRIME_1;
			end
		end
		case (cmd.op)
			DP_X_SRC:   x_q <= src_val;
			DP_MUL: begin
				if (mul_done && cmd.mdst == MD_X) begin
					x_q <= mul_p;
				end
				if (mul_done && cmd.mdst == MD_H) begin
					h_q <= mul_p;
				end
			end
			DP_ADDROT:  x_q <= {addsum[32:0], addsum[63:33]};
			DP_LANE_WR: lane_q[cmd.idx[1:0]] <= x_q;
			DP_H_CONV:  h_q <= conv;
			DP_H_SHORT: h_q <= seed_q + PRIME_5;
			DP_H_LEN:   h_q <= h_q + len_q;
			DP_H_XOR:   h_q <= h_q ^ x_q;
			DP_H_ROT:   h_q <= h_rot;
			DP_H_ADDK:  h_q <= h_q + kval(cmd.k);
			DP_H_SHR:   h_q <= h_shr;
			DP_DONE:    out_q <= h_q;
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign hash_value = out_q;

	assign st.need_stripe = need_stripe;
	assign st.in_last     = last_item;
	assign st.pend_cnt    = pc_q;
	assign st.nb          = nb_q;
	assign st.last        = last_q;
	assign st.long_msg    = (len_q >= 64'd32);
	assign st.mul_done    = mul_done;
	assign st.out_busy    = out_valid_q && !out_ready;
endmodule
`default_nettype wire

>>> design/xxh64_ctrl.sv
// Controller: sequences stripe rounds, lane merge, tail folding and avalanche.
`default_nettype none
module xxh64_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire xxh64_pkg::dp_status_t st,
	output xxh64_pkg::dp_cmd_t         cmd
);
	import xxh64_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_R_LOAD, S_R_MUL1, S_R_ADDROT, S_R_MUL2, S_LANE_WR,
		S_H_XOR, S_H_ROT, S_H_MUL, S_H_ADD, S_FIN, S_H_LEN, S_TAIL,
		S_Q_X, S_Q_MUL, S_Q_XOR, S_Q_ROT, S_Q_MULH, S_Q_ADD,
		S_BYTE, S_B_MUL, S_B_XOR, S_B_ROT, S_B_MULH,
		S_AV1, S_AV2, S_AV3, S_AV4, S_AV5, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_STRIPE,
		PH_MERGE,
		PH_FOLD
	} phase_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [1:0] li_q;
	logic [1:0] fi_q;
	logic [3:0] pos_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.op       = DP_NOP;
		cmd.src      = SRC_WORD;
		cmd.k        = K_P1;
		cmd.mdst     = MD_X;
		cmd.rot      = ROT_27;
		cmd.shr      = SHR_33;
		case (state_q)
			S_IDLE:     cmd.op = DP_ACCEPT;
			S_R_LOAD: begin
				cmd.op = DP_X_SRC;
				case (phase_q)
					PH_STRIPE: begin
						cmd.src = (li_q == 2'd3) ? SRC_WORD : SRC_PEND;
						cmd.idx = {1'b0, li_q};
					end
					PH_MERGE: begin
						cmd.src = SRC_LANE;
						cmd.idx = {1'b0, li_q};
					end
					default: begin
						cmd.src = (fi_q < st.pend_cnt) ? SRC_PEND : SRC_WORD;
						cmd.idx = {1'b0, fi_q};
					end
				endcase
			end
			S_R_MUL1: begin
				cmd.op = DP_MUL;
				cmd.k  = K_P2;
			end
			S_R_ADDROT: begin
				cmd.op       = DP_ADDROT;
				cmd.use_lane = (phase_q == PH_STRIPE);
				cmd.idx      = {1'b0, li_q};
			end
			S_R_MUL2:   cmd.op = DP_MUL;
			S_LANE_WR: begin
				cmd.op  = DP_LANE_WR;
				cmd.idx = {1'b0, li_q};
			end
			S_H_XOR, S_Q_XOR, S_B_XOR: cmd.op = DP_H_XOR;
			S_H_ROT:    cmd.op = DP_H_ROT;
			S_H_MUL, S_B_MULH: begin
				cmd.op   = DP_MUL;
				cmd.mdst = MD_H;
			end
			S_H_ADD: begin
				cmd.op = DP_H_ADDK;
				cmd.k  = K_P4;
			end
			S_FIN:      cmd.op = st.long_msg ? DP_H_CONV : DP_H_SHORT;
			S_H_LEN:    cmd.op = DP_H_LEN;
			S_Q_X: begin
				cmd.op  = DP_X_SRC;
				cmd.src = SRC_LO32;
			end
			S_Q_MUL:    cmd.op = DP_MUL;
			S_Q_ROT: begin
				cmd.op  = DP_H_ROT;
				cmd.rot = ROT_23;
			end
			S_Q_MULH: begin
				cmd.op   = DP_MUL;
				cmd.mdst = MD_H;
				cmd.k    = K_P2;
			end
			S_Q_ADD: begin
				cmd.op = DP_H_ADDK;
				cmd.k  = K_P3;
			end
			S_BYTE: begin
				cmd.op  = (pos_q < st.nb) ? DP_X_SRC : DP_NOP;
				cmd.src = SRC_BYTE;
				cmd.idx = pos_q[2:0];
			end
			S_B_MUL: begin
				cmd.op = DP_MUL;
				cmd.k  = K_P5;
			end
			S_B_ROT: begin
				cmd.op  = DP_H_ROT;
				cmd.rot = ROT_11;
			end
			S_AV1:      cmd.op = DP_H_SHR;
			S_AV2: begin
				cmd.op   = DP_MUL;
				cmd.mdst = MD_H;
				cmd.k    = K_P2;
			end
			S_AV3: begin
				cmd.op  = DP_H_SHR;
				cmd.shr = SHR_29;
			end
			S_AV4: begin
				cmd.op   = DP_MUL;
				cmd.mdst = MD_H;
				cmd.k    = K_P3;
			end
			S_AV5: begin
				cmd.op  = DP_H_SHR;
				cmd.shr = SHR_32;
			end
			S_OUT:      cmd.op = st.out_busy ? DP_NOP : DP_DONE;
			default:    cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_STRIPE;
			li_q    <= 2'd0;
			fi_q    <= 2'd0;
			pos_q   <= 4'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						li_q <= 2'd0;
						if (st.need_stripe) begin
							phase_q <= PH_STRIPE;
							state_q <= S_R_LOAD;
						end else if (st.in_last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_R_LOAD:   state_q <= S_R_MUL1;
				S_R_MUL1:   if (st.mul_done) state_q <= S_R_ADDROT;
				S_R_ADDROT: state_q <= S_R_MUL2;
				S_R_MUL2: begin
					if (st.mul_done) begin
						state_q <= (phase_q == PH_STRIPE) ? S_LANE_WR : S_H_XOR;
					end
				end
				S_LANE_WR: begin
					li_q <= li_q + 2'd1;
					if (li_q == 2'd3) begin
						state_q <= st.last ? S_FIN : S_IDLE;
					end else begin
						state_q <= S_R_LOAD;
					end
				end
				S_H_XOR:    state_q <= (phase_q == PH_FOLD) ? S_H_ROT : S_H_MUL;
				S_H_ROT:    state_q <= S_H_MUL;
				S_H_MUL:    if (st.mul_done) state_q <= S_H_ADD;
				S_H_ADD: begin
					if (phase_q == PH_MERGE) begin
						li_q    <= li_q + 2'd1;
						state_q <= (li_q == 2'd3) ? S_H_LEN : S_R_LOAD;
					end else if (fi_q < st.pend_cnt) begin
						fi_q    <= fi_q + 2'd1;
						state_q <= S_TAIL;
					end else begin
						state_q <= S_AV1;
					end
				end
				S_FIN: begin
					li_q    <= 2'd0;
					phase_q <= PH_MERGE;
					state_q <= st.long_msg ? S_R_LOAD : S_H_LEN;
				end
				S_H_LEN: begin
					fi_q    <= 2'd0;
					state_q <= S_TAIL;
				end
				S_TAIL: begin
					if (fi_q < st.pend_cnt || st.nb == 4'd8) begin
						phase_q <= PH_FOLD;
						state_q <= S_R_LOAD;
					end else if (st.nb >= 4'd4) begin
						state_q <= S_Q_X;
					end else begin
						pos_q   <= 4'd0;
						state_q <= S_BYTE;
					end
				end
				S_Q_X:      state_q <= S_Q_MUL;
				S_Q_MUL:    if (st.mul_done) state_q <= S_Q_XOR;
				S_Q_XOR:    state_q <= S_Q_ROT;
				S_Q_ROT:    state_q <= S_Q_MULH;
				S_Q_MULH:   if (st.mul_done) state_q <= S_Q_ADD;
				S_Q_ADD: begin
					pos_q   <= 4'd4;
					state_q <= S_BYTE;
				end
				S_BYTE:     state_q <= (pos_q < st.nb) ? S_B_MUL : S_AV1;
				S_B_MUL:    if (st.mul_done) state_q <= S_B_XOR;
				S_B_XOR:    state_q <= S_B_ROT;
				S_B_ROT:    state_q <= S_B_MULH;
				S_B_MULH: begin
					if (st.mul_done) begin
						pos_q   <= pos_q + 4'd1;
						state_q <= S_BYTE;
					end
				end
				S_AV1:      state_q <= S_AV2;
				S_AV2:      if (st.mul_done) state_q <= S_AV3;
				S_AV3:      state_q <= S_AV4;
				S_AV4:      if (st.mul_done) state_q <= S_AV5;
				S_AV5:      state_q <= S_OUT;
				S_OUT:      if (!st.out_busy) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/xxhash64_stream_hasher.sv
// Streaming XXH64 hasher, top level: ties controller and datapath together.
// A word that does not close a 32-byte stripe is taken while the controller
// stays idle. The word that closes a stripe runs four lane rounds on one
// shared multiplier that builds each 64-bit product from three 32x32 partial
// products, and that word holds off the input until the rounds are done. The
// last word adds the finish: a lane merge for messages of 32 bytes or more,
// a fold per buffered tail word, one for an 8-byte tail word, one for a
// 4-byte piece, one per single byte, and the avalanche. The result sits in an
// output register; a new message may start while it waits, but the next hash
// is held back until it has been taken.
`default_nettype none
`include "xxhash64_stream_hasher_macros.svh"
module xxhash64_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        last_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      hash_value
);
	import xxh64_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	xxh64_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	xxh64_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_item  (last_item),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.hash_value (hash_value),
		.cmd        (cmd),
		.st         (st)
	);

	// multiplier only runs while an item is being worked on
	`XXH_NEVER(a_idle_no_mul, in_ready && (cmd.op == DP_MUL), "multiplier active while idle")
	// the last word always leads into the finishing sequence
	`XXH_CHECK(a_last_busy, in_valid && in_ready && last_item |=> !in_ready, "idle after last word")
	// a hash appears only at the end of a finishing sequence
	`XXH_CHECK(a_out_from_fin, $rose(out_valid) |-> $past(!in_ready), "hash without finish")
endmodule
`default_nettype wire
